/* hw/rtl/whp_pkg.sv */
// shared constants and types for the wav header parser
package whp_pkg;

  localparam int HEADER_WINDOW = 512;
  localparam int POS_W = $clog2(HEADER_WINDOW);
  localparam int OFF_W = 33;

  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FACT = 32'h7463_6166;
  localparam logic [31:0] TAG_LIST = 32'h5453_494C;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam int WAVE_TAG_END = 11;
  localparam int FMT_LEN_END = 19;
  localparam int FMT_FIRST = 20;
  localparam int FMT_BYTES = 16;
  localparam int FMT_IDX_W = $clog2(FMT_BYTES);

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_WAVE = 2'd1;
  localparam logic [1:0] ST_NO_DATA = 2'd2;

  typedef struct packed {
    logic wave_ok;
    logic data_known;
    logic data_id_ok;
    logic data_found;
    logic opt_pending;
  } whp_flags_t;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] pos;
    logic [31:0]      word;
    logic [OFF_W-1:0] opt_off;
    logic [OFF_W-1:0] data_off;
    logic [31:0]      data_len;
    whp_flags_t       flags;
  } whp_state_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] bit_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [9:0]  data_offset;
    logic [31:0] data_length;
  } whp_res_t;

endpackage

/* hw/rtl/whp_if.sv */
// valid/ready channel interfaces for the file byte input and the header result
interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] file_byte;
  logic       first_byte;

  modport source (output valid, output file_byte, output first_byte, input ready);
  modport sink (input valid, input file_byte, input first_byte, output ready);
endinterface

interface whp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] audio_format;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [31:0] bit_rate;
  logic [15:0] block_align;
  logic [15:0] bits_per_sample;
  logic [9:0]  data_offset;
  logic [31:0] data_length;

  modport source (
    output valid, output status, output audio_format, output channel_count,
    output sample_rate, output bit_rate, output block_align,
    output bits_per_sample, output data_offset, output data_length,
    input ready
  );
  modport sink (
    input valid, input status, input audio_format, input channel_count,
    input sample_rate, input bit_rate, input block_align,
    input bits_per_sample, input data_offset, input data_length,
    output ready
  );
endinterface

/* hw/rtl/whp_step.sv */
// next-state and result logic for one file byte
module whp_step (
  input  whp_pkg::whp_state_t                    st,
  input  logic [7:0]                             file_byte,
  input  logic                                   first_byte,
  input  logic [whp_pkg::FMT_BYTES*8-1:0]        fmt_bytes,
  output whp_pkg::whp_state_t                    st_nxt,
  output logic                                   fmt_we,
  output logic [whp_pkg::FMT_IDX_W-1:0]          fmt_idx,
  output logic                                   res_vld,
  output whp_pkg::whp_res_t                      res
);

  whp_pkg::whp_state_t           cur;
  logic [whp_pkg::POS_W-1:0]     p;
  logic [whp_pkg::OFF_W:0]       pz;
  logic [whp_pkg::OFF_W:0]       opt_ext;
  logic [whp_pkg::OFF_W:0]       sum_d;
  logic [whp_pkg::OFF_W-1:0]     dsel;
  logic [whp_pkg::POS_W-1:0]     fmt_rel;
  logic [31:0]                   word;
  logic                          known_now;
  logic                          known_sel;
  logic                          id_sel;

  always_comb begin
    cur = st;
    if (first_byte) begin
      cur = '0;
    end
    st_nxt = cur;
    fmt_we = 1'b0;
    res_vld = 1'b0;
    res = '0;
    p = cur.pos;
    pz = (whp_pkg::OFF_W+1)'(p);
    opt_ext = {1'b0, cur.opt_off};
    word = {file_byte, cur.word[31:8]};
    fmt_rel = p - whp_pkg::POS_W'(whp_pkg::FMT_FIRST);
    fmt_idx = fmt_rel[whp_pkg::FMT_IDX_W-1:0];
    sum_d = opt_ext + (whp_pkg::OFF_W+1)'(8) + (whp_pkg::OFF_W+1)'(word);
    known_now = 1'b0;
    dsel = cur.data_off;
    known_sel = cur.flags.data_known;
    id_sel = cur.flags.data_id_ok;

    if (!cur.done) begin
      st_nxt.word = word;
      st_nxt.pos = p + 1'b1;

      if (p >= whp_pkg::POS_W'(whp_pkg::FMT_FIRST) &&
          p < whp_pkg::POS_W'(whp_pkg::FMT_FIRST + whp_pkg::FMT_BYTES)) begin
        fmt_we = 1'b1;
      end

      if (p == whp_pkg::POS_W'(whp_pkg::WAVE_TAG_END) && word == whp_pkg::TAG_WAVE) begin
        st_nxt.flags.wave_ok = 1'b1;
      end

      if (p == whp_pkg::POS_W'(whp_pkg::FMT_LEN_END)) begin
        st_nxt.opt_off = whp_pkg::OFF_W'(whp_pkg::FMT_FIRST) + whp_pkg::OFF_W'(word);
      end

      if (p >= whp_pkg::POS_W'(whp_pkg::FMT_FIRST)) begin
        // chunk id after fmt: fact or list is skipped when its header fits the window, anything else is taken as data
        if (!cur.flags.data_known && !cur.flags.opt_pending &&
            pz == opt_ext + (whp_pkg::OFF_W+1)'(3)) begin
          if (opt_ext + (whp_pkg::OFF_W+1)'(8) <= (whp_pkg::OFF_W+1)'(whp_pkg::HEADER_WINDOW) &&
              (word == whp_pkg::TAG_FACT || word == whp_pkg::TAG_LIST)) begin
            st_nxt.flags.opt_pending = 1'b1;
          end else begin
            st_nxt.data_off = cur.opt_off;
            st_nxt.flags.data_known = 1'b1;
            known_now = 1'b1;
          end
        end

        // size of the skipped chunk, saturating
        if (cur.flags.opt_pending && pz == opt_ext + (whp_pkg::OFF_W+1)'(7)) begin
          st_nxt.data_off = sum_d[whp_pkg::OFF_W] ? '1 : sum_d[whp_pkg::OFF_W-1:0];
          st_nxt.flags.opt_pending = 1'b0;
          st_nxt.flags.data_known = 1'b1;
        end

        // a data offset set from the skip length always lies beyond this byte
        if (known_now) begin
          dsel = cur.opt_off;
          known_sel = 1'b1;
        end
        if (known_sel) begin
          if (pz == {1'b0, dsel} + (whp_pkg::OFF_W+1)'(3) && word == whp_pkg::TAG_DATA) begin
            st_nxt.flags.data_id_ok = 1'b1;
            id_sel = 1'b1;
          end
          if (id_sel && pz == {1'b0, dsel} + (whp_pkg::OFF_W+1)'(7)) begin
            st_nxt.data_len = word;
            st_nxt.flags.data_found = 1'b1;
          end
        end
      end

      if (p == whp_pkg::POS_W'(whp_pkg::HEADER_WINDOW - 1)) begin
        st_nxt.done = 1'b1;
        res_vld = 1'b1;
        if (!st_nxt.flags.wave_ok) begin
          res.status = whp_pkg::ST_NOT_WAVE;
        end else if (!st_nxt.flags.data_found) begin
          res.status = whp_pkg::ST_NO_DATA;
        end else begin
          res.status = whp_pkg::ST_OK;
          res.audio_format = fmt_bytes[15:0];
          res.channel_count = fmt_bytes[31:16];
          res.sample_rate = fmt_bytes[63:32];
          res.bit_rate = {fmt_bytes[92:64], 3'b000};
          res.block_align = fmt_bytes[111:96];
          res.bits_per_sample = fmt_bytes[127:112];
          res.data_offset = st_nxt.data_off[9:0] + 10'd8;
          res.data_length = st_nxt.data_len;
        end
      end
    end
  end

endmodule

/* hw/rtl/wav_header_parser.sv */
// wav header parser: one file byte per cycle, one header result per window
// the last window byte is registered in the input stage, then its result in the output register once that is free
// throughput: one byte per cycle while the result side is free; a held result stalls input
// one result every HEADER_WINDOW bytes, set by the byte position counter
// reset clears the handshake and parse state; bytes are ignored until first_byte is set
module wav_header_parser (
  input logic         clk,
  input logic         rst_n,
  whp_in_if.sink      in_if,
  whp_out_if.source   out_if
);

  logic                                 s1_vld_r;
  logic [7:0]                           s1_byte_r;
  logic                                 s1_first_r;
  whp_pkg::whp_state_t                  st_r;
  whp_pkg::whp_state_t                  st_nxt;
  logic [7:0]                           fmt_r [whp_pkg::FMT_BYTES];
  logic [whp_pkg::FMT_BYTES*8-1:0]      fmt_bytes;
  logic                                 fmt_we;
  logic [whp_pkg::FMT_IDX_W-1:0]        fmt_idx;
  logic                                 res_vld;
  whp_pkg::whp_res_t                    res;
  logic                                 out_vld_r;
  whp_pkg::whp_res_t                    out_res_r;
  logic                                 out_free;
  logic                                 advance;

  assign out_free = !out_vld_r || out_if.ready;
  assign advance = s1_vld_r && out_free;
  assign in_if.ready = !s1_vld_r || out_free;

  always_comb begin
    for (int i = 0; i < whp_pkg::FMT_BYTES; i++) begin
      fmt_bytes[i*8 +: 8] = fmt_r[i];
    end
  end

  whp_step u_step (
    .st         (st_r),
    .file_byte  (s1_byte_r),
    .first_byte (s1_first_r),
    .fmt_bytes  (fmt_bytes),
    .st_nxt     (st_nxt),
    .fmt_we     (fmt_we),
    .fmt_idx    (fmt_idx),
    .res_vld    (res_vld),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      st_r <= '{done: 1'b1, default: '0};
    end else begin
      if (in_if.ready) begin
        s1_vld_r <= in_if.valid;
      end
      if (advance) begin
        st_r <= st_nxt;
      end
      if (out_free) begin
        out_vld_r <= advance && res_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_byte_r <= in_if.file_byte;
      s1_first_r <= in_if.first_byte;
    end
    if (advance && fmt_we) begin
      fmt_r[fmt_idx] <= s1_byte_r;
    end
    if (advance && res_vld) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid = out_vld_r;
  assign out_if.status = out_res_r.status;
  assign out_if.audio_format = out_res_r.audio_format;
  assign out_if.channel_count = out_res_r.channel_count;
  assign out_if.sample_rate = out_res_r.sample_rate;
  assign out_if.bit_rate = out_res_r.bit_rate;
  assign out_if.block_align = out_res_r.block_align;
  assign out_if.bits_per_sample = out_res_r.bits_per_sample;
  assign out_if.data_offset = out_res_r.data_offset;
  assign out_if.data_length = out_res_r.data_length;

endmodule

/* verif/wav_header_parser_tb.sv */
// testbench for the wav header parser: streams of file bytes in, parsed headers checked
module wav_header_parser_tb;
  import whp_pkg::*;

  localparam int CHUNK_HDR = 8;
  localparam int IDLE_LIMIT = 10000;
  localparam int HOLD_CYCLES = 3000;
  localparam int HOLD_AT = 6;
  localparam int HEADER_TARGET = 56;
  localparam logic [63:0] OFF_SAT = (64'd1 << OFF_W) - 64'd1;
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_FMT = 32'h2074_6d66;

  // tracks the header parse byte by byte and keeps the headers still owed by the block
  class header_tracker;
    whp_res_t    headers_due[$];
    int          mismatches;
    int          headers_made;
    int          headers_seen;
    bit          parsing;
    int unsigned pos;
    logic [31:0] word;
    logic [63:0] opt_off;
    logic [63:0] data_off;
    logic [63:0] fmt_lo;
    logic [63:0] fmt_hi;
    logic [31:0] data_len;
    whp_flags_t  fl;

    function new();
      mismatches = 0;
      headers_made = 0;
      headers_seen = 0;
      parsing = 1'b0;
      restart();
    endfunction

    function void restart();
      pos = 0;
      word = '0;
      opt_off = '0;
      data_off = '0;
      fmt_lo = '0;
      fmt_hi = '0;
      data_len = '0;
      fl = '0;
    endfunction

    function void take_byte(logic [7:0] b, logic first);
      whp_res_t    hdr;
      logic [63:0] d;
      if (first) begin
        restart();
        parsing = 1'b1;
      end
      if (!parsing) return;

      word = {b, word[31:8]};
      if (pos >= FMT_FIRST && pos < FMT_FIRST + 8)
        fmt_lo[8*(pos-FMT_FIRST) +: 8] = b;
      else if (pos >= FMT_FIRST + 8 && pos < FMT_FIRST + FMT_BYTES)
        fmt_hi[8*(pos-FMT_FIRST-8) +: 8] = b;

      if (pos == WAVE_TAG_END && word == TAG_WAVE) fl.wave_ok = 1'b1;
      if (pos == FMT_LEN_END) opt_off = 64'(FMT_FIRST) + 64'(word);

      if (pos >= FMT_FIRST) begin
        if (!fl.data_known && !fl.opt_pending && 64'(pos) == opt_off + 64'd3) begin
          // an optional chunk only counts when its whole header fits the window
          if (opt_off + CHUNK_HDR <= HEADER_WINDOW && (word == TAG_FACT || word == TAG_LIST)) begin
            fl.opt_pending = 1'b1;
          end else begin
            data_off = opt_off;
            fl.data_known = 1'b1;
          end
        end
        if (fl.opt_pending && 64'(pos) == opt_off + 64'd7) begin
          d = opt_off + CHUNK_HDR + 64'(word);
          data_off = (d > OFF_SAT) ? OFF_SAT : d;
          fl.opt_pending = 1'b0;
          fl.data_known = 1'b1;
        end
        if (fl.data_known) begin
          if (64'(pos) == data_off + 64'd3 && word == TAG_DATA) fl.data_id_ok = 1'b1;
          if (fl.data_id_ok && 64'(pos) == data_off + 64'd7) begin
            data_len = word;
            fl.data_found = 1'b1;
          end
        end
      end

      pos++;
      if (pos < HEADER_WINDOW) return;

      parsing = 1'b0;
      hdr = '0;
      if (!fl.wave_ok) begin
        hdr.status = ST_NOT_WAVE;
      end else if (!fl.data_found) begin
        hdr.status = ST_NO_DATA;
      end else begin
        hdr.status = ST_OK;
        hdr.audio_format = fmt_lo[15:0];
        hdr.channel_count = fmt_lo[31:16];
        hdr.sample_rate = fmt_lo[63:32];
        hdr.bit_rate = {fmt_hi[28:0], 3'b000};
        hdr.block_align = fmt_hi[47:32];
        hdr.bits_per_sample = fmt_hi[63:48];
        hdr.data_offset = 10'(data_off + CHUNK_HDR);
        hdr.data_length = data_len;
      end
      headers_due.push_back(hdr);
      headers_made++;
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task flag_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        flag_mismatch($sformatf("header %0d %s got 0x%0h, want 0x%0h",
                                headers_seen, name, got, want));
    endtask

    task check_header(whp_res_t got);
      whp_res_t want;
      if (headers_due.size() == 0) begin
        flag_mismatch($sformatf("header %0d arrived with none pending", headers_seen));
        headers_seen++;
        return;
      end
      want = headers_due.pop_front();
      flag_field("status", 32'(got.status), 32'(want.status));
      flag_field("audio_format", 32'(got.audio_format), 32'(want.audio_format));
      flag_field("channel_count", 32'(got.channel_count), 32'(want.channel_count));
      flag_field("sample_rate", got.sample_rate, want.sample_rate);
      flag_field("bit_rate", got.bit_rate, want.bit_rate);
      flag_field("block_align", 32'(got.block_align), 32'(want.block_align));
      flag_field("bits_per_sample", 32'(got.bits_per_sample), 32'(want.bits_per_sample));
      flag_field("data_offset", 32'(got.data_offset), 32'(want.data_offset));
      flag_field("data_length", got.data_length, want.data_length);
      headers_seen++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   hold_on = 1'b0;
  int   idle_cycles = 0;

  logic [7:0]  file_img [0:HEADER_WINDOW-1];
  logic [63:0] data_pos;

  header_tracker tracker = new();

  whp_in_if  in_ch ();
  whp_out_if out_ch ();

  wav_header_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #5 clk = ~clk;

  // little-endian write into the file image, clipped to the window
  function automatic void put_le(logic [63:0] off, logic [31:0] v, int n);
    int k;
    for (k = 0; k < n; k++)
      if (off + k < HEADER_WINDOW) file_img[off + k] = v[8*k +: 8];
  endfunction

  // random bytes with a riff header, fmt length, optional chunk and data chunk laid over them
  function automatic void make_wave(logic [31:0] fmt_len, bit with_opt,
                                    logic [31:0] opt_tag, logic [31:0] opt_len);
    int          i;
    logic [63:0] o;
    for (i = 0; i < HEADER_WINDOW; i++) file_img[i] = 8'($urandom);
    put_le(0, TAG_RIFF, 4);
    put_le(4, $urandom, 4);
    put_le(8, TAG_WAVE, 4);
    put_le(12, TAG_FMT, 4);
    put_le(16, fmt_len, 4);
    o = 64'(FMT_FIRST) + 64'(fmt_len);
    if (with_opt) begin
      put_le(o, opt_tag, 4);
      put_le(o + 4, opt_len, 4);
      o = o + CHUNK_HDR + 64'(opt_len);
    end
    put_le(o, TAG_DATA, 4);
    put_le(o + 4, $urandom, 4);
    data_pos = o;
  endfunction

  function automatic void put_fmt(logic [15:0] fmt, logic [15:0] chans, logic [31:0] rate,
                                  logic [31:0] byte_rate, logic [15:0] align,
                                  logic [15:0] bits);
    put_le(FMT_FIRST, 32'(fmt), 2);
    put_le(FMT_FIRST + 2, 32'(chans), 2);
    put_le(FMT_FIRST + 4, rate, 4);
    put_le(FMT_FIRST + 8, byte_rate, 4);
    put_le(FMT_FIRST + 12, 32'(align), 2);
    put_le(FMT_FIRST + 14, 32'(bits), 2);
  endfunction

  task automatic send_byte(logic [7:0] b, logic first, bit gappy);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.file_byte <= b;
    in_ch.first_byte <= first;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    gap = (gappy && !hold_on) ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_file(int len, bit gappy);
    int i;
    for (i = 0; i < len; i++) send_byte(file_img[i], i == 0, gappy);
  endtask

  task automatic send_stray(int n, bit gappy);
    int i;
    for (i = 0; i < n; i++) send_byte(8'($urandom), 1'b0, gappy);
  endtask

  // item monitors and the idle watchdog
  always @(posedge clk) begin : monitors
    whp_res_t got;
    if (rst_n === 1'b1 && in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
      tracker.take_byte(in_ch.file_byte, in_ch.first_byte);
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status = out_ch.status;
      got.audio_format = out_ch.audio_format;
      got.channel_count = out_ch.channel_count;
      got.sample_rate = out_ch.sample_rate;
      got.bit_rate = out_ch.bit_rate;
      got.block_align = out_ch.block_align;
      got.bits_per_sample = out_ch.bits_per_sample;
      got.data_offset = out_ch.data_offset;
      got.data_length = out_ch.data_length;
      tracker.check_header(got);
    end
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // header sink: random stalls, plus one long hold-off so the parser backs up
  initial begin : header_sink
    int stall;
    int taken;
    taken = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == HOLD_AT) begin
        hold_on = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
      end else begin
        stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      taken++;
    end
  end

  initial begin : stimulus
    int          kind;
    bit          gappy;
    bit          with_opt;
    logic [31:0] fmt_len;
    logic [31:0] opt_len;
    logic [31:0] opt_tag;

    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.file_byte <= '0;
    in_ch.first_byte <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes before any start are ignored
    send_stray(4, 1'b0);
    make_wave(16, 1'b0, TAG_FACT, 0);
    put_fmt(16'd1, 16'd2, 32'd44100, 32'd176400, 16'd4, 16'd16);
    send_file(HEADER_WINDOW, 1'b0);
    // bytes after a finished header are ignored too
    send_stray(3, 1'b1);

    // all-ones fields, byte rate wraps when scaled to bits
    make_wave(18, 1'b1, TAG_FACT, 4);
    put_fmt('1, '1, '1, '1, '1, '1);
    send_file(HEADER_WINDOW, 1'b1);

    make_wave(16, 1'b1, TAG_LIST, 26);
    put_fmt('0, '0, '0, '0, '0, '0);
    put_le(data_pos + 4, '1, 4);
    send_file(HEADER_WINDOW, 1'b0);

    // broken wave tag
    make_wave(16, 1'b0, TAG_FACT, 0);
    file_img[8] ^= 8'h01;
    send_file(HEADER_WINDOW, 1'b1);

    // broken data tag
    make_wave(16, 1'b0, TAG_FACT, 0);
    file_img[data_pos] ^= 8'h20;
    send_file(HEADER_WINDOW, 1'b0);

    // data header ending on the last window byte, then one byte too late
    make_wave(16, 1'b1, TAG_LIST, 460);
    send_file(HEADER_WINDOW, 1'b1);
    make_wave(16, 1'b1, TAG_LIST, 461);
    send_file(HEADER_WINDOW, 1'b0);

    // optional chunk header straddling the window end
    make_wave(486, 1'b1, TAG_FACT, 0);
    send_file(HEADER_WINDOW, 1'b1);

    // huge fmt length, huge optional chunk (offset far beyond the window), empty fmt chunk
    make_wave('1, 1'b0, TAG_FACT, 0);
    send_file(HEADER_WINDOW, 1'b0);
    make_wave(16, 1'b1, TAG_FACT, '1);
    send_file(HEADER_WINDOW, 1'b1);
    make_wave(0, 1'b0, TAG_FACT, 0);
    send_file(HEADER_WINDOW, 1'b0);

    // restart in mid-parse and on the last window byte
    make_wave(16, 1'b0, TAG_FACT, 0);
    send_file(300, 1'b1);
    send_file(HEADER_WINDOW - 1, 1'b0);
    send_file(HEADER_WINDOW, 1'b1);

    // random files: mostly well formed, some corrupted, truncated or pure noise
    while (tracker.headers_made < HEADER_TARGET) begin
      kind = $urandom_range(0, 99);
      gappy = $urandom_range(0, 1);
      with_opt = $urandom_range(0, 1);
      case ($urandom_range(0, 5))
        0: fmt_len = 16;
        1: fmt_len = 18;
        2: fmt_len = 40;
        3: fmt_len = $urandom_range(0, 120);
        4: fmt_len = $urandom_range(0, 480);
        default: fmt_len = $urandom;
      endcase
      case ($urandom_range(0, 9))
        6, 7, 8: opt_len = $urandom_range(0, 480);
        9: opt_len = $urandom;
        default: opt_len = $urandom_range(0, 60);
      endcase
      opt_tag = $urandom_range(0, 1) ? TAG_FACT : TAG_LIST;
      if ($urandom_range(0, 9) == 0) opt_tag = $urandom;
      make_wave(fmt_len, with_opt, opt_tag, opt_len);
      if (kind < 15) file_img[$urandom_range(0, 47)] ^= 8'(1 << $urandom_range(0, 7));
      if (kind >= 85) begin
        for (int i = 0; i < HEADER_WINDOW; i++) file_img[i] = 8'($urandom);
        if (kind >= 93) put_le(8, TAG_WAVE, 4);
      end
      if ($urandom_range(0, 4) == 0) send_stray($urandom_range(1, 5), gappy);
      if (kind >= 70 && kind < 85)
        send_file($urandom_range(1, HEADER_WINDOW - 1), gappy);
      else
        send_file(HEADER_WINDOW, gappy);
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (tracker.headers_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
